/* design/spike_limited_average_filter_unit_assert.svh */
// assertion macros for the spike limited average filter
// expects clk and rst_n in the scope of the including module
`ifndef SPIKE_LIMITED_AVERAGE_FILTER_UNIT_ASSERT_SVH
`define SPIKE_LIMITED_AVERAGE_FILTER_UNIT_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define SLAF_ASSERT_NOW(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// condition in one cycle that implies another in the next cycle
`define SLAF_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* design/slaf_pkg.sv */
// constants shared by the spike limited average filter
// no dependencies
package slaf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int INPUT_TAPS  = 7;
    localparam int OUTPUT_TAPS = 6;

    localparam int TAPS_TOTAL = INPUT_TAPS + OUTPUT_TAPS;
    localparam int IN_CELLS   = (INPUT_TAPS > 1) ? INPUT_TAPS - 1 : 1;

    localparam logic [SAMPLE_W-1:0] JUMP_THRESHOLD_RESET = SAMPLE_W'(50);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

    // width of the full tap sum
    localparam int SUM_W = $clog2(TAPS_TOTAL * ((2 ** SAMPLE_W) - 1) + 1);

    // exact reciprocal for dividing any SUM_W-bit value by TAPS_TOTAL
    localparam int RECIP_SHIFT = SUM_W + $clog2(TAPS_TOTAL);
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(TAPS_TOTAL) - 64'd1) / 64'(TAPS_TOTAL);
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = SUM_W + RECIP_W;

endpackage

/* design/slaf_cell.sv */
// one history cell of the filter delay line
// depends on slaf_pkg
module slaf_cell
    import slaf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift_en,
    input  logic [SAMPLE_W-1:0] din,
    output logic [SAMPLE_W-1:0] dout
);

    logic [SAMPLE_W-1:0] value_reg;
    logic [SAMPLE_W-1:0] value_next;

    assign value_next = shift_en ? din : value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign dout = value_reg;

endmodule

/* design/spike_limited_average_filter_unit.sv */
// a result word is registered and appears on m_tdata the cycle after its sample is taken
// one sample per cycle while the output is not stalled; s_tready = !m_tvalid | m_tready
// the jump test, running sum and divide by the tap count are combinational
// reset clears both history chains and the running sum, threshold goes to 50
// depends on slaf_pkg, slaf_cell and spike_limited_average_filter_unit_assert.svh
`include "spike_limited_average_filter_unit_assert.svh"

module spike_limited_average_filter_unit
    import slaf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [SAMPLE_W-1:0] cfg_wdata,  // jump_threshold
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,    // range_sample
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata     // filtered_range
);

    logic                accept;
    logic [SAMPLE_W-1:0] thr_reg;
    logic [SUM_W-1:0]    sum_hist_reg;
    logic [SUM_W-1:0]    sum_hist_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SAMPLE_W-1:0] out_data_reg;

    logic [SAMPLE_W-1:0] out_tap [OUTPUT_TAPS];
    logic [SAMPLE_W-1:0] prev_in;
    logic [SAMPLE_W-1:0] in_tail;
    logic [SAMPLE_W-1:0] in_add;
    logic [SAMPLE_W-1:0] last_out;

    logic                jump_up;
    logic                jump_down;
    logic [SAMPLE_W-1:0] acc_value;
    logic [SUM_W-1:0]    total;
    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0] quot;
    logic [SUM_W-1:0]    quot_rem;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign last_out = out_tap[0];

    // input history chain, absent with a single input tap
    generate
        if (INPUT_TAPS > 1)
        begin : g_in_chain
            logic [SAMPLE_W-1:0] in_tap [IN_CELLS];
            for (genvar i = 0; i < IN_CELLS; i++)
            begin : g_cell
                slaf_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (accept),
                    .din      ((i == 0) ? acc_value : in_tap[(i == 0) ? 0 : i - 1]),
                    .dout     (in_tap[i])
                );
            end
            assign prev_in = in_tap[0];
            assign in_tail = in_tap[IN_CELLS-1];
            assign in_add  = acc_value;
        end
        else
        begin : g_no_in_chain
            assign prev_in = '0;
            assign in_tail = '0;
            assign in_add  = '0;
        end
    endgenerate

    // output history chain, cell 0 holds the last result
    generate
        for (genvar j = 0; j < OUTPUT_TAPS; j++)
        begin : g_out_cell
            slaf_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (accept),
                .din      ((j == 0) ? quot : out_tap[(j == 0) ? 0 : j - 1]),
                .dout     (out_tap[j])
            );
        end
    endgenerate

    // slew limit against the last output
    always_comb
    begin
        jump_up   = ({1'b0, s_tdata} > ({1'b0, last_out} + {1'b0, thr_reg}));
        jump_down = (last_out != '0) &&
                    (({1'b0, s_tdata} + {1'b0, thr_reg}) < {1'b0, last_out});
        priority if (jump_up)
        begin
            acc_value = (prev_in == SAMPLE_MAX) ? SAMPLE_MAX : prev_in + SAMPLE_W'(1);
        end
        else if (jump_down)
        begin
            acc_value = (prev_in == '0) ? '0 : prev_in - SAMPLE_W'(1);
        end
        else
        begin
            acc_value = s_tdata;
        end
    end

    // divide by the tap count through the exact reciprocal
    assign total    = sum_hist_reg + SUM_W'(acc_value);
    assign prod     = PROD_W'(total) * PROD_W'(RECIP);
    assign quot     = prod[RECIP_SHIFT +: SAMPLE_W];
    assign quot_rem = total - SUM_W'(quot) * SUM_W'(TAPS_TOTAL);

    // running sum of everything held in the two chains
    assign sum_hist_next = sum_hist_reg + SUM_W'(in_add) + SUM_W'(quot)
                         - SUM_W'(in_tail) - SUM_W'(out_tap[OUTPUT_TAPS-1]);

    assign out_valid_next = accept ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= JUMP_THRESHOLD_RESET;
            sum_hist_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (accept)
            begin
                sum_hist_reg <= sum_hist_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= quot;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `SLAF_ASSERT_NOW(a_quot_exact, quot_rem < SUM_W'(TAPS_TOTAL), "reciprocal divide off")
    `SLAF_ASSERT_NEXT(a_accept_shows, accept, m_tvalid, "accepted word not presented")
    `SLAF_ASSERT_NEXT(a_hist_matches_out, accept, out_tap[0] == m_tdata, "output history out of step")
    `SLAF_ASSERT_NEXT(a_sum_holds, !accept, $stable(sum_hist_reg), "running sum moved without a word")

endmodule
